@@ design/qnorm_pkg.sv @@
// Package for the quaternion normalizer: widths, register codes and pipeline depths.
// Used by every module in design/.
`timescale 1ns / 1ps
package qnorm_pkg;
  localparam int FRAC_BITS  = 15;
  localparam int COMP_W     = 18;
  localparam int SQ_W       = 36;  // square of an 18-bit value, unsigned
  localparam int SUM_W      = 37;  // sum of four squares
  localparam int ROOT_W     = 19;  // floor sqrt of a 37-bit value
  localparam int MAG_W      = 18;  // magnitude of a component, up to 2^17
  localparam int DIVD_W     = MAG_W + FRAC_BITS;   // dividend width
  localparam int ROOT_STEPS = ROOT_W;              // one result bit per stage
  localparam int DIV_STEPS  = DIVD_W;              // one quotient bit per stage
  localparam int DEPTH      = 2 + ROOT_STEPS + DIV_STEPS + 1;
  localparam int ADDR_W     = 2;
  localparam logic [ADDR_W-1:0] REG_MIN_NORM_SQ = 2'd0;
  localparam logic signed [COMP_W-1:0] COMP_MAX = 18'sd131071;
  localparam logic signed [COMP_W-1:0] COMP_MIN = -18'sd131072;
endpackage

@@ design/quaternion_normalize.sv @@
// Top level of the quaternion normalizer: APB register, stream ports, pipeline, output skid.
// Depends on qnorm_pkg, qnorm_sumsq, qnorm_isqrt, qnorm_div.
`timescale 1ns / 1ps
// Usage:
//  s_tdata carries one quaternion (q_w, q_x, q_y, q_z, 18 bits each); m_tdata carries
//  n_w..n_z and the scaled flag. Both are stream channels; a request moves when
//  tvalid and tready are high at a clock edge.
//  One quaternion enters every cycle while the skid is empty. The pipeline is squaring
//  and summing, then 19 root stages (one bit each), 33 divide stages (one quotient bit
//  each, four lanes side by side), then one output register.
//  When the receiver stalls, the request leaving the output register is caught in a
//  one-entry skid register and the whole pipeline halts while the skid is full;
//  s_tready comes straight from a flop: it is high while the skid is empty.
//  min_norm_sq is written over APB at address 0; write it only while idle.
//  Reset (rst, synchronous) empties the pipeline and clears min_norm_sq.
module quaternion_normalize import qnorm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [71:0]       s_tdata,   // q_w, q_x, q_y, q_z
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [79:0]       m_tdata,   // n_w, n_x, n_y, n_z, scaled, zero fill
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  logic [SUM_W-1:0] min_norm_sq;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_MIN_NORM_SQ) ? 64'(min_norm_sq) : '0;
  always_ff @(posedge clk) begin
    if (rst) min_norm_sq <= '0;
    else if (psel && penable && pwrite && paddr == REG_MIN_NORM_SQ)
      min_norm_sq <= pwdata[SUM_W-1:0];
  end

  // pipeline advances every cycle unless the skid holds a stalled request
  logic en;
  logic [DEPTH-1:0] vld;
  logic skid_v;
  assign en = !skid_v;
  assign s_tready = en;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], s_tvalid};
  end

  logic signed [COMP_W-1:0] cin [4];
  for (genvar i = 0; i < 4; i++) begin : g_in
    assign cin[i] = s_tdata[i*COMP_W +: COMP_W];
  end

  // delay line for the raw components up to the divider input
  logic signed [COMP_W-1:0] cd [2+ROOT_STEPS+1][4];
  assign cd[0] = cin;
  for (genvar k = 0; k < 2 + ROOT_STEPS; k++) begin : g_cd
    always_ff @(posedge clk) if (en) cd[k+1] <= cd[k];
  end

  logic [SUM_W-1:0] sum;
  qnorm_sumsq u_sumsq (.clk, .en, .c(cin), .sum);

  logic [ROOT_W-1:0] root;
  qnorm_isqrt u_isqrt (.clk, .en, .s(sum), .root);

  // sum > threshold, carried alongside the root
  logic sc [ROOT_STEPS+DIV_STEPS+1];
  assign sc[0] = sum > min_norm_sq;
  for (genvar k = 0; k < ROOT_STEPS + DIV_STEPS; k++) begin : g_sc
    always_ff @(posedge clk) if (en) sc[k+1] <= sc[k];
  end

  // raw components carried across the divide for pass-through
  logic signed [COMP_W-1:0] pd [DIV_STEPS+1][4];
  assign pd[0] = cd[2+ROOT_STEPS];
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_pd
    always_ff @(posedge clk) if (en) pd[k+1] <= pd[k];
  end

  logic signed [COMP_W-1:0] qv [4];
  for (genvar i = 0; i < 4; i++) begin : g_lane
    // zero root only occurs on pass-through items; force 1 to keep the lane defined
    logic [ROOT_W-1:0] dsafe;
    assign dsafe = (root == '0) ? ROOT_W'(1) : root;
    qnorm_div u_div (.clk, .en, .c(cd[2+ROOT_STEPS][i]), .d(dsafe), .q_out(qv[i]));
  end

  // merge the lanes and register the result
  logic [79:0] res;
  logic scd;
  assign scd = sc[ROOT_STEPS+DIV_STEPS];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        res[i*COMP_W +: COMP_W] <= scd ? qv[i] : pd[DIV_STEPS][i];
      end
      res[72] <= scd;
      res[79:73] <= '0;
    end
  end

  // skid: holds the older request while the pipeline is frozen behind it
  logic [79:0] skid;
  always_ff @(posedge clk) begin
    if (rst) skid_v <= 1'b0;
    else if (skid_v) begin
      if (m_tready) skid_v <= 1'b0;
    end else if (vld[DEPTH-1] && !m_tready) skid_v <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (!skid_v) skid <= res;
  end

  assign m_tvalid = skid_v || vld[DEPTH-1];
  assign m_tdata  = skid_v ? skid : res;
endmodule

@@ design/qnorm_sumsq.sv @@
// Sum of squares of the four components, two registered stages.
// Depends on qnorm_pkg.
`timescale 1ns / 1ps
module qnorm_sumsq import qnorm_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [COMP_W-1:0] c [4],
  output logic [SUM_W-1:0]         sum
);
  logic [SQ_W-1:0] sq [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        // widen before the multiply so the full 36-bit square is kept
        sq[i] <= $unsigned(SQ_W'(c[i]) * SQ_W'(c[i]));
      end
      sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]) + SUM_W'(sq[3]);
    end
  end
endmodule

@@ design/qnorm_isqrt.sv @@
// Pipelined floor square root, one result bit per stage (restoring).
// Depends on qnorm_pkg.
`timescale 1ns / 1ps
module qnorm_isqrt import qnorm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  s,
  output logic [ROOT_W-1:0] root
);
  // stage k decides root bit ROOT_W-1-k
  logic [SUM_W-1:0]  rem [ROOT_STEPS+1];
  logic [ROOT_W-1:0] r   [ROOT_STEPS+1];
  assign rem[0] = s;
  assign r[0]   = '0;
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [2*ROOT_W:0] trial;
    assign trial = ((2*ROOT_W+1)'(r[k]) << (B + 1)) + ((2*ROOT_W+1)'(1) << (2*B));
    logic [SUM_W-1:0]  rem_q;
    logic [ROOT_W-1:0] r_q;
    always_ff @(posedge clk) begin
      if (en) begin
        if ((2*ROOT_W+1)'(rem[k]) >= trial) begin
          rem_q <= SUM_W'((2*ROOT_W+1)'(rem[k]) - trial);
          r_q   <= r[k] | (ROOT_W'(1) << B);
        end else begin
          rem_q <= rem[k];
          r_q   <= r[k];
        end
      end
    end
    assign rem[k+1] = rem_q;
    assign r[k+1]   = r_q;
  end
  assign root = r[ROOT_STEPS];
endmodule

@@ design/qnorm_div.sv @@
// One lane: pipelined restoring divide of |c|<<FRAC_BITS by the root, then sign and saturate.
// Depends on qnorm_pkg.
`timescale 1ns / 1ps
module qnorm_div import qnorm_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [COMP_W-1:0] c,
  input  logic [ROOT_W-1:0]        d,
  output logic signed [COMP_W-1:0] q_out
);
  logic [DIVD_W-1:0] num [DIV_STEPS+1];
  logic [ROOT_W:0]   rem [DIV_STEPS+1];
  logic [ROOT_W-1:0] dv  [DIV_STEPS+1];
  logic              ng  [DIV_STEPS+1];
  logic [MAG_W-1:0]  mag;
  assign mag    = c[COMP_W-1] ? MAG_W'(-c) : MAG_W'(c);
  assign num[0] = DIVD_W'(mag) << FRAC_BITS;
  assign rem[0] = '0;
  assign dv[0]  = d;
  assign ng[0]  = c[COMP_W-1];
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
    logic [ROOT_W+1:0] sh;
    assign sh = {rem[k], num[k][DIVD_W-1]};
    logic [DIVD_W-1:0] num_q;
    logic [ROOT_W:0]   rem_q;
    logic [ROOT_W-1:0] dv_q;
    logic              ng_q;
    always_ff @(posedge clk) begin
      if (en) begin
        dv_q <= dv[k];
        ng_q <= ng[k];
        if (sh >= (ROOT_W+2)'(dv[k])) begin
          rem_q <= (ROOT_W+1)'(sh - (ROOT_W+2)'(dv[k]));
          num_q <= {num[k][DIVD_W-2:0], 1'b1};
        end else begin
          rem_q <= (ROOT_W+1)'(sh);
          num_q <= {num[k][DIVD_W-2:0], 1'b0};
        end
      end
    end
    assign num[k+1] = num_q;
    assign rem[k+1] = rem_q;
    assign dv[k+1]  = dv_q;
    assign ng[k+1]  = ng_q;
  end
  // quotient ends in num
  logic [DIVD_W-1:0] qt;
  assign qt = num[DIV_STEPS];
  always_comb begin
    if (ng[DIV_STEPS]) begin
      if (qt > DIVD_W'(131072)) q_out = COMP_MIN;
      else q_out = COMP_W'(-$signed({1'b0, qt}));
    end else begin
      if (qt > DIVD_W'(131071)) q_out = COMP_MAX;
      else q_out = COMP_W'(qt);
    end
  end
endmodule

@@ sim/quaternion_normalize_test.sv @@
// Testbench for quaternion_normalize: drives quaternions on the stream input, predicts
// each normalized result in a scoreboard class and checks every output request.
// Depends on qnorm_pkg and the design/ RTL.
`timescale 1ns / 1ps
module quaternion_normalize_test;
  import qnorm_pkg::*;

  typedef struct packed {
    logic signed [COMP_W-1:0] z, y, x, w;
  } quat_t;

  typedef struct packed {
    logic                     scaled;
    logic signed [COMP_W-1:0] z, y, x, w;
  } norm_t;

  class norm_scoreboard;
    logic [SUM_W-1:0] min_sq;
    norm_t            pending[$];
    int               errors;

    function new();
      min_sq = '0;
      errors = 0;
    endfunction

    function logic [ROOT_W-1:0] floor_root(logic [SUM_W-1:0] s);
      logic [ROOT_W-1:0] r;
      r = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
        logic [ROOT_W-1:0] t;
        t = r | (ROOT_W'(1) << b);
        if (40'(t) * 40'(t) <= 40'(s)) r = t;
      end
      return r;
    endfunction

    function logic signed [COMP_W-1:0] scale(logic signed [COMP_W-1:0] c,
                                              logic [ROOT_W-1:0] n);
      longint mag, q;
      mag = (c < 0) ? -longint'(c) : longint'(c);
      q = (mag <<< FRAC_BITS) / longint'(n);
      if (c < 0) return (q > 131072) ? COMP_MIN : COMP_W'(-q);
      return (q > 131071) ? COMP_MAX : COMP_W'(q);
    endfunction

    function void note_quat(quat_t q);
      logic [SUM_W-1:0] s;
      logic [ROOT_W-1:0] n;
      norm_t r;
      s = SUM_W'(longint'(q.w) * q.w) + SUM_W'(longint'(q.x) * q.x)
        + SUM_W'(longint'(q.y) * q.y) + SUM_W'(longint'(q.z) * q.z);
      if (s > min_sq) begin
        n = floor_root(s);
        r = '{1'b1, scale(q.z, n), scale(q.y, n), scale(q.x, n), scale(q.w, n)};
      end else begin
        r = '{1'b0, q.z, q.y, q.x, q.w};
      end
      pending.push_back(r);
    endfunction

    function void check_norm(norm_t got);
      norm_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.w !== e.w) begin $error("n_w exp %0d got %0d", e.w, got.w); errors++; end
      if (got.x !== e.x) begin $error("n_x exp %0d got %0d", e.x, got.x); errors++; end
      if (got.y !== e.y) begin $error("n_y exp %0d got %0d", e.y, got.y); errors++; end
      if (got.z !== e.z) begin $error("n_z exp %0d got %0d", e.z, got.z); errors++; end
      if (got.scaled !== e.scaled) begin
        $error("scaled exp %0d got %0d", e.scaled, got.scaled);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = DEPTH + 8;
  localparam int STALL_LIMIT = 4000;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [71:0] s_tdata;
  logic [79:0] m_tdata;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [63:0] pwdata, prdata;

  norm_scoreboard sb = new();
  bit quiet_sink;
  int idle_cycles;

  quaternion_normalize dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random stall bursts unless quiet_sink is set, checks every accepted request
  initial begin
    int burst;
    m_tready = 1'b0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_norm(norm_t'(m_tdata[72:0]));
      if (quiet_sink) m_tready <= 1'b1;
      else if (burst > 0) begin
        burst--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8) - 1;
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_min_sq(logic [63:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_MIN_NORM_SQ; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.min_sq = v[SUM_W-1:0];
  endtask

  task automatic send_quat(quat_t q, bit gaps);
    int g;
    if (gaps && $urandom_range(0, 5) == 0) begin
      g = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= q;
    do @(posedge clk); while (!s_tready);
    sb.note_quat(q);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic signed [COMP_W-1:0] rand_comp(int mode);
    case (mode)
      0: return COMP_W'($urandom);
      1: return COMP_W'($urandom_range(0, 64)) - 18'sd32;
      2: return ($urandom_range(0, 1)) ? COMP_MAX : COMP_MIN;
      default: return COMP_W'($urandom_range(0, 65535)) - 18'sd32768;
    endcase
  endfunction

  initial begin
    quat_t q;
    int mode;
    quiet_sink = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, extremes, tiny values, unit quaternions
    send_quat('{default: 18'sd0}, 0);
    send_quat('{default: COMP_MAX}, 0);
    send_quat('{default: COMP_MIN}, 0);
    send_quat('{18'sd0, 18'sd0, 18'sd0, COMP_MIN}, 0);
    send_quat('{18'sd0, 18'sd0, 18'sd0, 18'sd1}, 0);
    send_quat('{18'sd0, 18'sd0, 18'sd0, -18'sd1}, 0);
    send_quat('{18'sd0, 18'sd0, 18'sd1, -18'sd1}, 0);
    send_quat('{18'sd0, -18'sd32768, 18'sd0, 18'sd0}, 0);
    send_quat('{COMP_MAX, COMP_MIN, 18'sd1, -18'sd1}, 0);
    send_quat('{18'sd3, -18'sd4, 18'sd0, 18'sd0}, 0);
    drain();
    // all-ones register value is truncated to 37 bits: everything passes through
    write_min_sq(64'hFFFF_FFFF_FFFF_FFFF);
    send_quat('{default: COMP_MIN}, 0);
    send_quat('{default: COMP_MAX}, 0);
    send_quat('{18'sd0, 18'sd0, 18'sd0, 18'sd5}, 0);
    drain();
    // threshold exactly at a sum: equal passes, one above scales
    write_min_sq(64'd25);
    send_quat('{18'sd3, -18'sd4, 18'sd0, 18'sd0}, 0);
    send_quat('{18'sd3, -18'sd4, 18'sd1, 18'sd0}, 0);
    send_quat('{18'sd0, 18'sd5, 18'sd0, 18'sd0}, 0);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_min_sq(64'd0);
        1: write_min_sq(64'd1 << 30);
        2: write_min_sq(64'h10_0000_0000);
        3: write_min_sq({$urandom, $urandom});
        default: write_min_sq(64'd0);
      endcase
      if (phase == 4) quiet_sink = 1'b1;
      for (int i = 0; i < 100; i++) begin
        mode = $urandom_range(0, 3);
        q = '{rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode)};
        send_quat(q, phase != 4);
      end
      drain();
    end

    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

@@ sim.f @@
design/qnorm_pkg.sv
design/qnorm_sumsq.sv
design/qnorm_isqrt.sv
design/qnorm_div.sv
design/quaternion_normalize.sv
sim/quaternion_normalize_test.sv
